### design/uitp_pkg.sv
// Package for the unsigned integer text parser.
// Holds the parse phase and radix types, the length cap and the digit and
// overflow bound helpers. No dependencies.
package uitp_pkg;

	localparam int MAX_LEN = 4096;
	localparam int POS_W = 12;
	localparam int POS_CAP_I = (MAX_LEN - 1) > 4095 ? 4095 : (MAX_LEN - 1);
	localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] DEC_BOUND_LO = 64'd1844674407370955161;
	localparam logic [63:0] DEC_BOUND_HI = 64'd1844674407370955160;
	localparam logic [63:0] OCT_BOUND = 64'h1FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] HEX_BOUND = 64'h0FFF_FFFF_FFFF_FFFF;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_LEAD   = 5'b00010,
		PH_SIGNED = 5'b00100,
		PH_ZERO   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} digit_t;

	// Digit value of a character in the given radix; valid is low for a non-digit.
	function automatic digit_t digit_of(radix_t radix, logic [7:0] c);
		digit_t d;
		d.valid = 1'b0;
		d.value = 4'd0;
		if (radix == RADIX_OCT) begin
			if (c >= "0" && c <= "7") begin
				d.valid = 1'b1;
				d.value = c[3:0];
			end
		end else if (c >= "0" && c <= "9") begin
			d.valid = 1'b1;
			d.value = c[3:0];
		end else if (radix == RADIX_HEX) begin
			if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
				d.valid = 1'b1;
				d.value = 4'(c[2:0] + 3'd1) + 4'd8;
			end
		end
		return d;
	endfunction

	// (2^64 - 1 - d) / base for the digits that the radix admits.
	function automatic logic [63:0] bound_of(radix_t radix, logic [3:0] d);
		logic [63:0] b;
		case (radix)
			RADIX_OCT: b = OCT_BOUND;
			RADIX_HEX: b = HEX_BOUND;
			default:   b = (d <= 4'd5) ? DEC_BOUND_LO : DEC_BOUND_HI;
		endcase
		return b;
	endfunction

	// accum * base using shifts, plus one add for decimal.
	function automatic logic [63:0] scale(radix_t radix, logic [63:0] a);
		logic [63:0] r;
		case (radix)
			RADIX_OCT: r = {a[60:0], 3'b000};
			RADIX_HEX: r = {a[59:0], 4'b0000};
			default:   r = {a[60:0], 3'b000} + {a[62:0], 1'b0};
		endcase
		return r;
	endfunction

endpackage

### design/unsigned_integer_text_parser.sv
// Top level of the unsigned integer text parser.
// Uses uitp_pkg for the phase and radix types and the digit helpers.
// Single module: input register, parse logic and result register.

// Parses one character per transfer, one transfer per clock when the result
// side keeps up. A character is captured in the input register, then the
// parse step updates the state and, when the number ends, loads the result
// register. The input side stalls only while a held result waits for
// m_tready. Set s_tuser on the first character of each string; characters
// after a result and before the next start are dropped without a result.
// end_offset saturates at 4095.
module unsigned_integer_text_parser
	import uitp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [63:0] value, [75:64] end_offset, [79:76] zero
	output logic [1:0]  m_tuser    // [0] overflowed, [1] no_digits
);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             first_s1;

	phase_t           phase_q;
	logic             negative_q;
	radix_t           radix_q;
	logic [63:0]      accum_q;
	logic [POS_W-1:0] position_q;

	logic             out_valid_q;
	logic [63:0]      value_q;
	logic [POS_W-1:0] offset_q;
	logic             ovf_q;
	logic             nod_q;

	logic             advance;
	logic             proc;

	phase_t           ph;
	logic             neg_c;
	radix_t           radix_c;
	logic [63:0]      acc_c;
	logic [POS_W-1:0] pos_c;

	phase_t           phase_d;
	logic             negative_d;
	radix_t           radix_d;
	logic [63:0]      accum_d;
	logic             emit;
	logic [63:0]      emit_value;
	logic             emit_ovf;
	logic             emit_nod;

	logic             lead_digit;
	logic             take;
	radix_t           take_radix;
	logic [63:0]      take_acc;
	digit_t           dig;

	assign advance  = !out_valid_q || m_tready;
	assign proc     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_comb begin
		ph      = first_s1 ? PH_LEAD : phase_q;
		neg_c   = first_s1 ? 1'b0 : negative_q;
		radix_c = first_s1 ? RADIX_DEC : radix_q;
		acc_c   = first_s1 ? 64'd0 : accum_q;
		pos_c   = first_s1 ? '0 : position_q;

		phase_d    = ph;
		negative_d = neg_c;
		radix_d    = radix_c;
		accum_d    = acc_c;
		emit       = 1'b0;
		emit_value = 64'd0;
		emit_ovf   = 1'b0;
		emit_nod   = 1'b0;
		lead_digit = 1'b0;
		take       = 1'b0;
		take_radix = radix_c;
		take_acc   = acc_c;

		case (ph)
			PH_LEAD: begin
				if (ch_s1 == "-") begin
					negative_d = 1'b1;
					phase_d    = PH_SIGNED;
				end else if (ch_s1 == "+") begin
					phase_d = PH_SIGNED;
				end else if (!(ch_s1 inside {" ", 8'h09})) begin
					lead_digit = 1'b1;
				end
			end
			PH_SIGNED: lead_digit = 1'b1;
			PH_ZERO: begin
				accum_d = 64'd0;
				phase_d = PH_DIGITS;
				if (ch_s1 inside {"x", "X"}) begin
					radix_d = RADIX_HEX;
				end else begin
					radix_d    = RADIX_OCT;
					take       = 1'b1;
					take_radix = RADIX_OCT;
					take_acc   = 64'd0;
				end
			end
			PH_DIGITS: take = 1'b1;
			default: ;
		endcase

		// The first character after the whitespace and sign.
		if (lead_digit) begin
			if (ch_s1 == "0") begin
				phase_d = PH_ZERO;
			end else if (ch_s1 inside {["1":"9"]}) begin
				radix_d = RADIX_DEC;
				accum_d = {60'd0, ch_s1[3:0]};
				phase_d = PH_DIGITS;
			end else begin
				emit     = 1'b1;
				emit_nod = 1'b1;
			end
		end

		dig = digit_of(take_radix, ch_s1);
		if (take) begin
			if (!dig.valid) begin
				emit       = 1'b1;
				emit_value = neg_c ? 64'd0 - take_acc : take_acc;
			end else if (take_acc >= bound_of(take_radix, dig.value)) begin
				emit       = 1'b1;
				emit_value = ALL_ONES;
				emit_ovf   = 1'b1;
			end else begin
				accum_d = scale(take_radix, take_acc) + {60'd0, dig.value};
			end
		end

		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1    <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			negative_q <= 1'b0;
			radix_q    <= RADIX_DEC;
			accum_q    <= 64'd0;
			position_q <= '0;
		end else if (proc) begin
			phase_q    <= phase_d;
			negative_q <= negative_d;
			radix_q    <= radix_d;
			accum_q    <= accum_d;
			// Idle characters leave the position alone.
			if (ph != PH_IDLE && !emit && pos_c < POS_CAP) begin
				position_q <= pos_c + 1'b1;
			end else begin
				position_q <= pos_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			value_q  <= emit_value;
			offset_q <= pos_c;
			ovf_q    <= emit_ovf;
			nod_q    <= emit_nod;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, offset_q, value_q};
	assign m_tuser  = {nod_q, ovf_q};

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && valid_s1))
		else $error("input stalled without a blocked result");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("overflow and no-digit flags both set");

	a_overflow_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == ALL_ONES))
		else $error("overflow result is not all ones");

	a_no_digit_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[63:0] == 64'd0))
		else $error("no-digit result is not zero");

	a_emit_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && emit) |=> (phase_q == PH_IDLE))
		else $error("parser did not stop after a result");

endmodule

### bench/parse_result_checker.sv
// Checker for the unsigned integer text parser: watches both stream channels,
// predicts the parse results and compares them field by field.
// Depends on uitp_pkg for the phase and radix types and the position cap.
module parse_result_checker
	import uitp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] first
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,   // [63:0] value, [75:64] end_offset, [79:76] zero
	input  logic [1:0]  m_tuser,   // [0] overflowed, [1] no_digits
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0]      value;
		logic [POS_W-1:0] end_offset;
		logic             overflowed;
		logic             no_digits;
	} number_t;

	number_t          numbers_q[$];
	phase_t           ph;
	logic             neg;
	radix_t           rdx;
	logic [63:0]      acc;
	logic [POS_W-1:0] pos;

	task automatic close_number(input logic [63:0] v, input logic ovf, input logic nod);
		number_t r;
		r.value = v;
		r.end_offset = pos;
		r.overflowed = ovf;
		r.no_digits = nod;
		numbers_q.push_back(r);
		ph = PH_IDLE;
	endtask

	task automatic add_digit(input logic [7:0] c, output logic done);
		logic        ok;
		logic [63:0] d;
		logic [63:0] base;
		ok = 1'b0;
		d = '0;
		if (rdx == RADIX_OCT) begin
			if (c >= "0" && c <= "7") begin
				ok = 1'b1;
				d = 64'(c[3:0]);
			end
		end else if (c >= "0" && c <= "9") begin
			ok = 1'b1;
			d = 64'(c[3:0]);
		end else if (rdx == RADIX_HEX && c >= "a" && c <= "f") begin
			ok = 1'b1;
			d = 64'(c - "a") + 64'd10;
		end else if (rdx == RADIX_HEX && c >= "A" && c <= "F") begin
			ok = 1'b1;
			d = 64'(c - "A") + 64'd10;
		end
		case (rdx)
			RADIX_HEX: base = 64'd16;
			RADIX_OCT: base = 64'd8;
			default:   base = 64'd10;
		endcase
		done = 1'b1;
		if (!ok) begin
			close_number(neg ? 64'd0 - acc : acc, 1'b0, 1'b0);
		end else if (acc >= (ALL_ONES - d) / base) begin
			// The bound is conservative: it stops one digit early on some values.
			close_number(ALL_ONES, 1'b1, 1'b0);
		end else begin
			acc = acc * base + d;
			done = 1'b0;
		end
	endtask

	task automatic parse_char(input logic [7:0] c, input logic start);
		logic done;
		done = 1'b0;
		if (start) begin
			ph = PH_LEAD;
			neg = 1'b0;
			rdx = RADIX_DEC;
			acc = '0;
			pos = '0;
		end
		if (ph == PH_IDLE)
			return;
		case (ph)
			PH_LEAD, PH_SIGNED: begin
				if (ph == PH_LEAD && (c == " " || c == "\t")) begin
				end else if (ph == PH_LEAD && c == "-") begin
					neg = 1'b1;
					ph = PH_SIGNED;
				end else if (ph == PH_LEAD && c == "+") begin
					ph = PH_SIGNED;
				end else if (c == "0") begin
					ph = PH_ZERO;
				end else if (c >= "1" && c <= "9") begin
					rdx = RADIX_DEC;
					acc = 64'(c[3:0]);
					ph = PH_DIGITS;
				end else begin
					close_number('0, 1'b0, 1'b1);
					done = 1'b1;
				end
			end
			PH_ZERO: begin
				acc = '0;
				ph = PH_DIGITS;
				if (c == "x" || c == "X") begin
					rdx = RADIX_HEX;
				end else begin
					rdx = RADIX_OCT;
					add_digit(c, done);
				end
			end
			default: add_digit(c, done);
		endcase
		if (!done && pos < POS_CAP)
			pos = pos + 1'b1;
	endtask

	task automatic check_field(input string name, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		number_t got;
		number_t want;
		if (!arst_n) begin
			numbers_q.delete();
			errors = 0;
			pending <= 0;
			ph = PH_IDLE;
			neg = 1'b0;
			rdx = RADIX_DEC;
			acc = '0;
			pos = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[63:0], m_tdata[75:64], m_tuser[0], m_tuser[1]};
				if (numbers_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected nothing, actual %h",
						$time, got);
				end else begin
					want = numbers_q.pop_front();
					check_field("value", want.value, got.value);
					check_field("end_offset", 64'(want.end_offset), 64'(got.end_offset));
					check_field("overflowed", 64'(want.overflowed), 64'(got.overflowed));
					check_field("no_digits", 64'(want.no_digits), 64'(got.no_digits));
				end
			end
			if (s_tvalid && s_tready)
				parse_char(s_tdata, s_tuser);
			pending <= numbers_q.size();
		end
	end

endmodule

### bench/tb_unsigned_integer_text_parser.sv
// Top of the testbench for the unsigned integer text parser: drives strings
// into the block, pulls results with random back-pressure and gives the verdict.
// Depends on the parser RTL, uitp_pkg and parse_result_checker.
module tb_unsigned_integer_text_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import uitp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	int          errors;
	int          pending;
	logic        quiet;
	int          holds_asked;
	int          holds_done;
	int          sent;
	logic [7:0]  line_buf[$];

	unsigned_integer_text_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	parse_result_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stalls, none while quiet, and one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (holds_asked != holds_done) begin
				m_tready <= 1'b0;
				repeat (250) @(negedge clk);
				holds_done++;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 27);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_char(input logic [7:0] c, input logic start);
		while (!quiet && $urandom_range(0, 99) < 27) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i], i == 0);
		sent += line_buf.size();
	endtask

	task automatic send_text(input string s);
		line_buf.delete();
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
		send_line();
	endtask

	// Whitespace, sign, radix prefix, digits and usually a terminator, all random.
	task automatic make_number_line();
		radix_t     r;
		int         ndig;
		int         v;
		line_buf.delete();
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 3)) line_buf.push_back($urandom_range(0, 1) ? " " : "\t");
		case ($urandom_range(0, 3))
			0:       line_buf.push_back("-");
			1:       line_buf.push_back("+");
			default: ;
		endcase
		r = radix_t'($urandom_range(0, 2));
		ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 6);
		case (r)
			RADIX_OCT: line_buf.push_back("0");
			RADIX_HEX: begin
				line_buf.push_back("0");
				line_buf.push_back($urandom_range(0, 1) ? "x" : "X");
			end
			default: begin
				if (ndig > 0) begin
					line_buf.push_back(8'("0" + $urandom_range(1, 9)));
					ndig--;
				end
			end
		endcase
		repeat (ndig) begin
			case (r)
				RADIX_OCT: line_buf.push_back(8'("0" + $urandom_range(0, 7)));
				RADIX_HEX: begin
					v = $urandom_range(0, 15);
					if (v < 10)
						line_buf.push_back(8'("0" + v));
					else
						line_buf.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
				end
				default: line_buf.push_back(8'("0" + $urandom_range(0, 9)));
			endcase
		end
		case ($urandom_range(0, 7))
			0:       ;
			1, 2:    line_buf.push_back(8'($urandom_range(0, 255)));
			3:       line_buf.push_back(8'h00);
			4:       line_buf.push_back(" ");
			5:       line_buf.push_back(",");
			6:       line_buf.push_back(";");
			default: line_buf.push_back(r == RADIX_OCT ? "9" : "g");
		endcase
	endtask

	initial begin
		logic pressed;
		logic paused;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		quiet = 1'b0;
		holds_asked = 0;
		sent = 0;
		pressed = 1'b0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed strings.
		send_char(8'hFF, 1'b0);
		send_text(" \t-12");
		send_char(8'h00, 1'b0);
		send_text("0Xg");
		send_char("a", 1'b0);
		send_text("+z");
		send_text("078");
		send_text("5");
		send_text("0xFf!");

		// Decimal values on both sides of the overflow bound.
		send_text("18446744073709551605;");
		send_text("18446744073709551606;");
		send_text("18446744073709551610;");

		// Strings longer than the position counter, once before and once inside the digits.
		line_buf.delete();
		repeat (4100) line_buf.push_back($urandom_range(0, 1) ? " " : "\t");
		line_buf.push_back("7");
		line_buf.push_back(";");
		send_line();
		line_buf.delete();
		repeat (4100) line_buf.push_back("0");
		line_buf.push_back("1");
		line_buf.push_back("7");
		line_buf.push_back(8'h00);
		send_line();

		sent = 0;
		while (sent < 500) begin
			if (!pressed && sent >= 150) begin
				holds_asked++;
				pressed = 1'b1;
			end
			if (!paused && sent >= 300) begin
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
				paused = 1'b1;
			end
			quiet = (sent >= 350 && sent < 450);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					sent++;
				end
			end else begin
				make_number_line();
				send_line();
				repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (5) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### unsigned_integer_text_parser.f
design/uitp_pkg.sv
design/unsigned_integer_text_parser.sv
bench/parse_result_checker.sv
bench/tb_unsigned_integer_text_parser.sv
